// File: design/mhdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhdg_pkg
// Shared widths, register indexes, control structs and the CORDIC angle table
// for the magnetometer heading core.
// ----------------------------------------------------------------------------
package mhdg_pkg;

    // Field widths
    localparam int IN_W        = 16;   // raw sample and bias width
    localparam int GAIN_W      = 24;   // Q8.16 gain width
    localparam int GAIN_FRAC   = 16;
    localparam int BEARING_W   = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Stream widths
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;

    // CORDIC datapath
    localparam int PRESCALE_SH = 8;    // samples enter the CORDIC times 256
    localparam int Z_W         = 26;   // angle accumulator, Q16 degrees
    localparam int Z_FRAC      = 16;
    localparam int ATAN_IDX_W  = 5;

    // Parameter defaults
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam logic signed [Z_W-1:0]      Z_PLUS_90  = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0]      Z_MINUS_90 = -Z_PLUS_90;
    localparam logic signed [BEARING_W-1:0] BEARING_MAX = 9'sd180;
    localparam logic signed [BEARING_W-1:0] BEARING_MIN = -9'sd180;
    localparam logic signed [BEARING_W:0]   WRAP_180    = 10'sd180;
    localparam logic signed [BEARING_W:0]   WRAP_360    = 10'sd360;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_X       = 3'd0,
        REG_BIAS_Y       = 3'd1,
        REG_SCALE_X      = 3'd2,
        REG_SCALE_Y      = 3'd3,
        REG_AXES_SWAPPED = 3'd4
    } t_cfg_reg;

    // Opcode carried in tuser
    localparam logic OP_MEASURE  = 1'b0;
    localparam logic OP_SET_ZERO = 1'b1;

    typedef struct packed {
        logic start;
    } t_cordic_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_sts;

    // atan(2^-i) in degrees, Q16
    function automatic logic [Z_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(2949120);
            5'd1:    v = Z_W'(1740967);
            5'd2:    v = Z_W'(919879);
            5'd3:    v = Z_W'(466945);
            5'd4:    v = Z_W'(234379);
            5'd5:    v = Z_W'(117304);
            5'd6:    v = Z_W'(58666);
            5'd7:    v = Z_W'(29335);
            5'd8:    v = Z_W'(14668);
            5'd9:    v = Z_W'(7334);
            5'd10:   v = Z_W'(3667);
            5'd11:   v = Z_W'(1833);
            5'd12:   v = Z_W'(917);
            5'd13:   v = Z_W'(458);
            5'd14:   v = Z_W'(229);
            5'd15:   v = Z_W'(115);
            5'd16:   v = Z_W'(57);
            5'd17:   v = Z_W'(29);
            5'd18:   v = Z_W'(14);
            5'd19:   v = Z_W'(7);
            5'd20:   v = Z_W'(4);
            5'd21:   v = Z_W'(2);
            5'd22:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: design/mhdg_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhdg_scale
// Shared hard-iron unit: subtract bias, multiply by Q8.16 gain, truncate
// toward zero and saturate to SAMPLE_WIDTH bits.
// ----------------------------------------------------------------------------
module mhdg_scale #(
    parameter int SAMPLE_WIDTH = mhdg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic signed [mhdg_pkg::IN_W-1:0]   i_raw,
    input  logic signed [mhdg_pkg::IN_W-1:0]   i_bias,
    input  logic        [mhdg_pkg::GAIN_W-1:0] i_gain,
    output logic signed [SAMPLE_WIDTH-1:0]     o_val
);

    localparam int DW = mhdg_pkg::IN_W + 1;
    localparam int PW = DW + mhdg_pkg::GAIN_W;
    localparam int QW = PW - mhdg_pkg::GAIN_FRAC;
    localparam logic signed [QW:0] LIM_HI = (QW+1)'((1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [QW:0] LIM_LO = -LIM_HI - (QW+1)'(1);

    logic signed [DW-1:0] w_diff;
    logic        [DW-1:0] w_mag;
    logic        [PW-1:0] w_prod;
    logic        [QW-1:0] w_q;
    logic signed [QW:0]   w_sq;

    assign w_diff = {i_raw[mhdg_pkg::IN_W-1], i_raw} - {i_bias[mhdg_pkg::IN_W-1], i_bias};
    assign w_mag  = w_diff[DW-1] ? DW'(-w_diff) : DW'(w_diff);
    assign w_prod = PW'(w_mag) * PW'(i_gain);
    assign w_q    = w_prod[PW-1:mhdg_pkg::GAIN_FRAC];
    // restore the sign after the magnitude product (truncates toward zero)
    assign w_sq   = w_diff[DW-1] ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});

    always_comb begin
        if (w_sq > LIM_HI) begin
            o_val = LIM_HI[SAMPLE_WIDTH-1:0];
        end else if (w_sq < LIM_LO) begin
            o_val = LIM_LO[SAMPLE_WIDTH-1:0];
        end else begin
            o_val = w_sq[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

// File: design/mhdg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhdg_cordic
// Iterative vectoring CORDIC: one rotation step per cycle on a shared
// shift/add datapath, angle accumulated in Q16 degrees.
// ----------------------------------------------------------------------------
module mhdg_cordic #(
    parameter int CORDIC_STEPS = mhdg_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_WIDTH = mhdg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mhdg_pkg::t_cordic_ctl                  i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_vx,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_vy,
    output mhdg_pkg::t_cordic_sts                  o_sts,
    output logic signed [mhdg_pkg::BEARING_W-1:0]  o_deg
);

    localparam int XW    = SAMPLE_WIDTH + mhdg_pkg::PRESCALE_SH + 3;
    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam int ZW    = mhdg_pkg::Z_W;
    localparam int DMW   = ZW - mhdg_pkg::Z_FRAC;

    typedef enum logic {C_IDLE, C_RUN} t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_step;
    logic signed [XW-1:0]  r_x;
    logic signed [XW-1:0]  r_y;
    logic signed [ZW-1:0]  r_z;
    logic                  r_zero;
    logic                  r_done;

    logic signed [XW-1:0]  w_px, w_py, w_x0, w_y0;
    logic signed [ZW-1:0]  w_z0;
    logic signed [XW-1:0]  w_xs, w_ys;
    logic signed [ZW-1:0]  w_at;
    logic        [ZW-1:0]  w_zmag;
    logic        [DMW-1:0] w_dmag;
    logic        [7:0]     w_mag8;

    // Prescale and fold the left half plane onto the right one
    assign w_px = XW'(i_vx) <<< mhdg_pkg::PRESCALE_SH;
    assign w_py = XW'(i_vy) <<< mhdg_pkg::PRESCALE_SH;

    always_comb begin
        if (w_px < 0) begin
            if (w_py >= 0) begin
                w_x0 = w_py;
                w_y0 = -w_px;
                w_z0 = mhdg_pkg::Z_PLUS_90;
            end else begin
                w_x0 = -w_py;
                w_y0 = w_px;
                w_z0 = mhdg_pkg::Z_MINUS_90;
            end
        end else begin
            w_x0 = w_px;
            w_y0 = w_py;
            w_z0 = '0;
        end
    end

    assign w_xs = r_x >>> r_step;
    assign w_ys = r_y >>> r_step;
    assign w_at = $signed(mhdg_pkg::atan_deg(mhdg_pkg::ATAN_IDX_W'(r_step)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_ctl.start) begin
                        r_x     <= w_x0;
                        r_y     <= w_y0;
                        r_z     <= w_z0;
                        r_zero  <= (i_vx == '0) && (i_vy == '0);
                        r_step  <= '0;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    // rotate toward the x axis
                    if (r_y >= 0) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end
                    if (r_step == LAST) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_state == C_RUN);
    assign o_sts.done = r_done;

    // Truncate toward zero to whole degrees and clamp to +/-180
    assign w_zmag = r_z[ZW-1] ? ZW'(-r_z) : ZW'(r_z);
    assign w_dmag = w_zmag[ZW-1:mhdg_pkg::Z_FRAC];
    assign w_mag8 = (w_dmag > DMW'(180)) ? 8'd180 : w_dmag[7:0];

    always_comb begin
        if (r_zero) begin
            o_deg = '0;
        end else if (r_z[ZW-1]) begin
            o_deg = -$signed({1'b0, w_mag8});
        end else begin
            o_deg = $signed({1'b0, w_mag8});
        end
    end

endmodule

// File: design/mhdg_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhdg_wrap
// Relative bearing: subtract the zero offset and wrap into -180..180.
// ----------------------------------------------------------------------------
module mhdg_wrap (
    input  logic signed [mhdg_pkg::BEARING_W-1:0] i_real,
    input  logic signed [mhdg_pkg::BEARING_W-1:0] i_offset,
    output logic signed [mhdg_pkg::BEARING_W-1:0] o_rel
);

    localparam int DW = mhdg_pkg::BEARING_W + 1;

    logic signed [DW-1:0] w_diff;
    logic signed [DW-1:0] w_neg;
    logic signed [DW-1:0] w_mod;
    logic signed [DW-1:0] w_rel;

    assign w_diff = {i_real[DW-2], i_real} - {i_offset[DW-2], i_offset};
    assign w_neg  = -w_diff;

    always_comb begin
        w_mod = '0;
        w_rel = w_diff;
        if (w_diff < -mhdg_pkg::WRAP_180) begin
            w_mod = (w_neg == mhdg_pkg::WRAP_360) ? '0 : w_neg - mhdg_pkg::WRAP_180;
            w_rel = mhdg_pkg::WRAP_180 - w_mod;
        end else if (w_diff > mhdg_pkg::WRAP_180) begin
            w_mod = (w_diff == mhdg_pkg::WRAP_360) ? '0 : w_diff - mhdg_pkg::WRAP_180;
            w_rel = w_mod - mhdg_pkg::WRAP_180;
        end
    end

    assign o_rel = w_rel[DW-2:0];

endmodule

// File: design/magnetometer_heading_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_heading_core
// Hard-iron compensated compass heading: bias, gain and saturation per axis,
// iterative CORDIC atan2, truncation to whole degrees, zero-offset wrap.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Beat contents
//  --------  ----  ----------------------------------------------------------
//  s (in)    in    tdata: raw_x [15:0], raw_y [31:16]; tuser: opcode
//  m (out)   out   tdata: real_bearing [8:0], relative_bearing [17:9], 0 pad
//  cfg       in    we / idx / data: bias_x, bias_y, scale_x, scale_y, swap
//
//  From acceptance, a beat passes through the shared gain multiplier (X then
//  Y), the CORDIC load, one rotation per cycle, the hand-back of the done
//  flag to the sequencer and the wrap into the output register.
//  The next beat is taken only once that result is loaded, so beats never
//  overlap: the single shift/add CORDIC datapath serves one beat at a time,
//  and o_s_tready is high only while the sequencer is idle.
//  A finished result waits in the output register while the next beat is
//  taken; the wrap stage holds until that register is free.
//  Reset is synchronous, active low, and clears the sequencers, the output
//  valid, the configuration registers and the offset.
// ----------------------------------------------------------------------------
module magnetometer_heading_core #(
    parameter int CORDIC_STEPS = mhdg_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_WIDTH = mhdg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [mhdg_pkg::S_TDATA_W-1:0]      i_s_tdata,   // raw_x, raw_y
    input  logic                                i_s_tuser,   // opcode
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [mhdg_pkg::M_TDATA_W-1:0]      o_m_tdata,   // real, relative, pad
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [mhdg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mhdg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IW  = mhdg_pkg::IN_W;
    localparam int BW  = mhdg_pkg::BEARING_W;
    localparam int PAD = mhdg_pkg::M_TDATA_W - 2 * BW;

    typedef enum logic [2:0] {
        S_IDLE, S_SCALE_X, S_SCALE_Y, S_START, S_RUN, S_FINISH
    } t_state;

    // Configuration registers
    logic signed [IW-1:0]                r_bias_x, r_bias_y;
    logic [mhdg_pkg::GAIN_W-1:0]         r_scale_x, r_scale_y;
    logic                                r_swap;

    // Sequencer and payload
    t_state                              r_state;
    logic                                r_op;
    logic signed [IW-1:0]                r_raw_x, r_raw_y;
    logic signed [SAMPLE_WIDTH-1:0]      r_cx, r_cy;
    logic signed [BW-1:0]                r_zero_offset;
    logic                                r_m_valid;
    logic signed [BW-1:0]                r_real, r_rel;

    logic signed [IW-1:0]                w_sc_raw, w_sc_bias;
    logic [mhdg_pkg::GAIN_W-1:0]         w_sc_gain;
    logic signed [SAMPLE_WIDTH-1:0]      w_sc_val;
    mhdg_pkg::t_cordic_ctl               w_cctl;
    mhdg_pkg::t_cordic_sts               w_csts;
    logic signed [SAMPLE_WIDTH-1:0]      w_cx_in, w_cy_in;
    logic signed [BW-1:0]                w_deg;
    logic signed [BW-1:0]                w_offset;
    logic signed [BW-1:0]                w_rel;
    logic                                w_in_acc;
    logic                                w_load;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_x  <= '0;
            r_bias_y  <= '0;
            r_scale_x <= '0;
            r_scale_y <= '0;
            r_swap    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mhdg_pkg::REG_BIAS_X:       r_bias_x  <= i_cfg_data[IW-1:0];
                mhdg_pkg::REG_BIAS_Y:       r_bias_y  <= i_cfg_data[IW-1:0];
                mhdg_pkg::REG_SCALE_X:      r_scale_x <= i_cfg_data[mhdg_pkg::GAIN_W-1:0];
                mhdg_pkg::REG_SCALE_Y:      r_scale_y <= i_cfg_data[mhdg_pkg::GAIN_W-1:0];
                mhdg_pkg::REG_AXES_SWAPPED: r_swap    <= i_cfg_data[0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------ shared gain unit
    // X in the S_SCALE_X state, Y in the S_SCALE_Y state that follows
    assign w_sc_raw  = (r_state == S_SCALE_Y) ? r_raw_y   : r_raw_x;
    assign w_sc_bias = (r_state == S_SCALE_Y) ? r_bias_y  : r_bias_x;
    assign w_sc_gain = (r_state == S_SCALE_Y) ? r_scale_y : r_scale_x;

    mhdg_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_scale (
        .i_raw  (w_sc_raw),
        .i_bias (w_sc_bias),
        .i_gain (w_sc_gain),
        .o_val  (w_sc_val)
    );

    // ----------------------------------------------------------------- CORDIC
    // atan2(y, x) normally; a swapped mounting computes atan2(x, y)
    assign w_cx_in     = r_swap ? r_cy : r_cx;
    assign w_cy_in     = r_swap ? r_cx : r_cy;
    assign w_cctl.start = (r_state == S_START);

    mhdg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cctl),
        .i_vx    (w_cx_in),
        .i_vy    (w_cy_in),
        .o_sts   (w_csts),
        .o_deg   (w_deg)
    );

    // ------------------------------------------------------------------ wrap
    // A set-zero beat takes its own bearing as offset, so it reports 0
    assign w_offset = (r_op == mhdg_pkg::OP_SET_ZERO) ? w_deg : r_zero_offset;

    mhdg_wrap u_wrap (
        .i_real   (w_deg),
        .i_offset (w_offset),
        .o_rel    (w_rel)
    );

    // ------------------------------------------------------------- sequencer
    assign w_in_acc = i_s_tvalid && o_s_tready;
    assign w_load   = (r_state == S_FINISH) && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_m_valid     <= 1'b0;
            r_zero_offset <= '0;
        end else begin
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= i_s_tuser;
                        r_raw_x <= i_s_tdata[IW-1:0];
                        r_raw_y <= i_s_tdata[2*IW-1:IW];
                        r_state <= S_SCALE_X;
                    end
                end
                S_SCALE_X: begin
                    r_cx    <= w_sc_val;
                    r_state <= S_SCALE_Y;
                end
                S_SCALE_Y: begin
                    r_cy    <= w_sc_val;
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_csts.done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // hold until the output register is free
                    if (w_load) begin
                        r_real        <= w_deg;
                        r_rel         <= w_rel;
                        r_zero_offset <= w_offset;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{PAD{1'b0}}, r_rel, r_real};

    // ------------------------------------------------------------ assertions
    a_idle_cordic_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_csts.busy)
        else $error("CORDIC busy while sequencer idle");

    a_accept_starts_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SCALE_X))
        else $error("accepted beat did not start the gain pass");

    a_set_zero_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == mhdg_pkg::OP_SET_ZERO) |=> (r_rel == '0))
        else $error("set-zero beat reported nonzero relative bearing");

    a_real_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_real <= mhdg_pkg::BEARING_MAX && r_real >= mhdg_pkg::BEARING_MIN))
        else $error("real bearing outside -180..180");

    a_done_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_csts.done |-> (r_state == S_RUN))
        else $error("CORDIC done outside run state");

endmodule

// File: tb/sv/magnetometer_heading_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_heading_core_tb
// Self-checking bench for the compass heading core. A directed table covers
// reset values, axis extremes, gain saturation, the zero vector, the negative
// X axis, axis swapping and zero-offset wrap-around. Random register settings
// and samples follow. Beats are predicted by a local bit-exact model of the
// compensation, CORDIC and wrap logic or taken from typed-in table bearings,
// and compared on arrival. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module magnetometer_heading_core_tb;
    import mhdg_pkg::*;

    localparam int STEPS           = CORDIC_STEPS_DEF;
    localparam int SAMPLE_W        = SAMPLE_WIDTH_DEF;
    localparam int ATAN_LEN        = 24;
    localparam int HALF_TURN       = 180;
    localparam int MAX_GAP         = 12;
    localparam int RAND_PHASES     = 10;
    localparam int BEATS_PER_PHASE = 170;
    // tail window, long enough for two results from acceptance to output
    localparam int TAIL_CYCLES     = 2 * (STEPS + 5) + 8;
    localparam int N_DIRECTED      = 23;

    // register sets used by the directed table
    localparam logic [1:0] CFG_RESET     = 2'd0;
    localparam logic [1:0] CFG_UNITY     = 2'd1;
    localparam logic [1:0] CFG_HIGH_GAIN = 2'd2;

    // atan(2^-i) in degrees, Q16
    localparam longint ATAN_Q16 [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [BEARING_W-1:0] abs_deg;
        logic signed [BEARING_W-1:0] rel_deg;
    } bearing_t;

    typedef struct packed {
        logic [1:0]         cfg_set;
        logic               op;
        logic [IN_W-1:0]    x;
        logic [IN_W-1:0]    y;
        logic               has_exp;   // expected bearings typed in below
        logic [BEARING_W-1:0] e_abs;
        logic [BEARING_W-1:0] e_rel;
    } dir_row_t;

    // raw_x and raw_y are given as read by the sensor, before bias removal
    localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
        // zero gains after reset: every heading collapses to the zero vector
        '{CFG_RESET, OP_MEASURE,  16'h7FFF,     16'h8000,     1'b1, 9'sd0, 9'sd0},
        '{CFG_RESET, OP_SET_ZERO, 16'h8000,     16'h7FFF,     1'b1, 9'sd0, 9'sd0},
        '{CFG_RESET, OP_MEASURE,  16'sd0,       16'sd0,       1'b1, 9'sd0, 9'sd0},
        // unity gains, bias (100, -200): raw equal to bias is the zero vector
        '{CFG_UNITY, OP_MEASURE,  16'sd100,     -16'sd200,    1'b1, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'sd1100,    -16'sd200,    1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'sd100,     16'sd800,     1'b0, 9'sd0, 9'sd0},
        // heading on the negative X axis
        '{CFG_UNITY, OP_MEASURE,  -16'sd900,    -16'sd200,    1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'sd100,     -16'sd1200,   1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'h7FFF,     16'h7FFF,     1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'h8000,     16'h8000,     1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'h8000,     16'h7FFF,     1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'h7FFF,     16'h8000,     1'b0, 9'sd0, 9'sd0},
        // move the zero, then look across it so the difference wraps
        '{CFG_UNITY, OP_SET_ZERO, 16'sd600,     16'sd300,     1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  -16'sd900,    -16'sd200,    1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'sd100,     -16'sd1200,   1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_SET_ZERO, -16'sd900,    -16'sd201,    1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  -16'sd900,    -16'sd199,    1'b0, 9'sd0, 9'sd0},
        '{CFG_UNITY, OP_MEASURE,  16'sd100,     16'sd800,     1'b0, 9'sd0, 9'sd0},
        // maximum X gain saturates; axes swapped
        '{CFG_HIGH_GAIN, OP_MEASURE,  16'sd1,   16'sd1,       1'b0, 9'sd0, 9'sd0},
        '{CFG_HIGH_GAIN, OP_MEASURE,  16'sd200, -16'sd1,      1'b0, 9'sd0, 9'sd0},
        '{CFG_HIGH_GAIN, OP_MEASURE,  -16'sd200, 16'sd5,      1'b0, 9'sd0, 9'sd0},
        '{CFG_HIGH_GAIN, OP_MEASURE,  16'sd0,   -16'sd20000,  1'b0, 9'sd0, 9'sd0},
        '{CFG_HIGH_GAIN, OP_SET_ZERO, -16'sd3,  16'sd0,       1'b0, 9'sd0, 9'sd0}
    };

    // DUT ports
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata;    // raw_x [15:0], raw_y [31:16]
    logic                   i_s_tuser;    // opcode
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [M_TDATA_W-1:0]   o_m_tdata;    // real_bearing [8:0], relative_bearing [17:9]
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // local copy of the block's registers and zero offset
    logic signed [IN_W-1:0]      bias_x_q;
    logic signed [IN_W-1:0]      bias_y_q;
    logic [GAIN_W-1:0]           gain_x_q;
    logic [GAIN_W-1:0]           gain_y_q;
    logic                        swap_q;
    logic signed [BEARING_W-1:0] zero_q;

    bearing_t pending_bearings [$];

    int  failures;
    int  beats_sent;
    int  beats_checked;
    int  zero_sets;
    int  settings_loaded;
    bit  quiet_s;
    bit  quiet_m;

    magnetometer_heading_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Remove bias, apply the Q8.16 gain on the magnitude, truncate toward
    // zero and clip to the signed sample range.
    function automatic longint comp_axis(input longint raw, input longint bias,
                                         input longint unsigned gain);
        longint          d;
        longint unsigned mag;
        longint          q;
        longint          lim;
        d   = raw - bias;
        mag = (d < 0) ? -d : d;
        q   = longint'((mag * gain) >> GAIN_FRAC);
        lim = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        if (d < 0)
            q = -q;
        if (q > lim)
            q = lim;
        if (q < -lim - 1)
            q = -lim - 1;
        return q;
    endfunction

    // atan2(num, den) in whole degrees by vectoring CORDIC, Q16 accumulator
    function automatic int cordic_heading(input longint num, input longint den);
        longint xv;
        longint yv;
        longint zv;
        longint xs;
        longint ys;
        longint tmp;
        int     i;
        if (num == 0 && den == 0)
            return 0;
        xv = den * (longint'(1) <<< PRESCALE_SH);
        yv = num * (longint'(1) <<< PRESCALE_SH);
        zv = 0;
        // fold the left half plane into the right one first
        if (xv < 0) begin
            if (yv >= 0) begin
                tmp = xv; xv = yv; yv = -tmp;
                zv  = 90 * 65536;
            end else begin
                tmp = xv; xv = -yv; yv = tmp;
                zv  = -90 * 65536;
            end
        end
        for (i = 0; i < STEPS && i < ATAN_LEN; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv = xv + ys; yv = yv - xs; zv = zv + ATAN_Q16[i];
            end else begin
                xv = xv - ys; yv = yv + xs; zv = zv - ATAN_Q16[i];
            end
        end
        zv = (zv < 0) ? -((-zv) >>> Z_FRAC) : (zv >>> Z_FRAC);
        if (zv > HALF_TURN)
            zv = HALF_TURN;
        if (zv < -HALF_TURN)
            zv = -HALF_TURN;
        return int'(zv);
    endfunction

    // Bearings for one sample; a set-zero beat also moves the stored offset.
    function automatic bearing_t next_bearing(input logic op,
                                              input logic signed [IN_W-1:0] rx,
                                              input logic signed [IN_W-1:0] ry);
        longint   cx;
        longint   cy;
        int       hd;
        int       diff;
        bearing_t b;
        cx = comp_axis(rx, bias_x_q, gain_x_q);
        cy = comp_axis(ry, bias_y_q, gain_y_q);
        hd = swap_q ? cordic_heading(cx, cy) : cordic_heading(cy, cx);
        if (op == OP_SET_ZERO)
            zero_q = BEARING_W'(hd);
        diff = hd - int'(zero_q);
        if (diff < -HALF_TURN)
            diff = HALF_TURN - ((-diff) % HALF_TURN);
        else if (diff > HALF_TURN)
            diff = -HALF_TURN + (diff % HALF_TURN);
        b.abs_deg = BEARING_W'(hd);
        b.rel_deg = BEARING_W'(diff);
        return b;
    endfunction

    // Random sample: mostly close to the bias so headings spread over the
    // circle, sometimes exactly on it, sometimes anywhere.
    function automatic logic signed [IN_W-1:0] pick_raw(input logic signed [IN_W-1:0] bias);
        logic signed [IN_W-1:0] off;
        case ($urandom_range(0, 7))
            0:       return IN_W'($urandom);
            1:       return bias;
            default: begin
                off = $signed(IN_W'($urandom_range(0, 4095))) - 16'sd2048;
                return bias + off;
            end
        endcase
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Write all five registers back to back; call only with the core idle.
    task automatic load_config(input logic signed [IN_W-1:0] bx,
                               input logic signed [IN_W-1:0] by,
                               input logic [GAIN_W-1:0] gx,
                               input logic [GAIN_W-1:0] gy,
                               input logic sw);
        write_reg(REG_BIAS_X,       {8'h00, bx});
        write_reg(REG_BIAS_Y,       {8'h00, by});
        write_reg(REG_SCALE_X,      gx);
        write_reg(REG_SCALE_Y,      gy);
        write_reg(REG_AXES_SWAPPED, {23'd0, sw});
        i_cfg_we <= 1'b0;
        bias_x_q = bx;
        bias_y_q = by;
        gain_x_q = gx;
        gain_y_q = gy;
        swap_q   = sw;
        settings_loaded++;
    endtask

    // Drop valid and hold until every outstanding bearing has been checked.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_bearings.size() != 0)
            @(posedge i_clk);
    endtask

    // Idle for the given gap, present one beat and hold it until accepted.
    // Valid is left high so a back-to-back beat follows without a gap.
    task automatic send_beat(input logic op, input logic signed [IN_W-1:0] rx,
                             input logic signed [IN_W-1:0] ry, input int gap,
                             input logic use_fixed, input bearing_t fixed_b);
        bearing_t b;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {ry, rx};
        do @(posedge i_clk); while (!o_s_tready);
        // the predictor always runs so the zero offset tracks the core
        b = next_bearing(op, rx, ry);
        pending_bearings.push_back(use_fixed ? fixed_b : b);
        beats_sent++;
        if (op == OP_SET_ZERO)
            zero_sets++;
    endtask

    // Stimulus: directed table, then random register phases.
    initial begin : stimulus
        dir_row_t               row;
        bearing_t               fixed_b;
        logic [1:0]             cur_set;
        logic                   op;
        logic signed [IN_W-1:0] rx;
        logic signed [IN_W-1:0] ry;
        logic signed [IN_W-1:0] bx;
        logic signed [IN_W-1:0] by;
        logic [GAIN_W-1:0]      gx;
        logic [GAIN_W-1:0]      gy;
        int                     r;
        int                     ph;
        int                     n;
        int                     gap;

        failures        = 0;
        beats_sent      = 0;
        beats_checked   = 0;
        zero_sets       = 0;
        settings_loaded = 0;
        quiet_s         = 1'b0;
        bias_x_q        = '0;
        bias_y_q        = '0;
        gain_x_q        = '0;
        gain_y_q        = '0;
        swap_q          = 1'b0;
        zero_q          = '0;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= OP_MEASURE;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_BIAS_X;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; reload registers whenever the row's set changes
        cur_set = CFG_RESET;
        for (r = 0; r < N_DIRECTED; r++) begin
            row = DIR_ROWS[r];
            if (row.cfg_set != cur_set) begin
                drain_results();
                if (row.cfg_set == CFG_UNITY)
                    load_config(16'sd100, -16'sd200, 24'h010000, 24'h010000, 1'b0);
                else
                    load_config(16'sd0, 16'sd0, 24'hFFFFFF, 24'h020000, 1'b1);
                cur_set = row.cfg_set;
            end
            fixed_b.abs_deg = row.e_abs;
            fixed_b.rel_deg = row.e_rel;
            send_beat(row.op, row.x, row.y, $urandom_range(0, MAX_GAP),
                      row.has_exp, fixed_b);
        end

        // random phases: first the corner settings, then random ones
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: load_config(16'sd0, 16'sd0, 24'h010000, 24'h010000, 1'b0);
                1: load_config(16'h8000, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
                2: load_config(16'h7FFF, 16'h8000, 24'h000000, 24'hFFFFFF, 1'b0);
                3: load_config(16'sd0, 16'sd0, 24'h000001, 24'h000100, 1'b1);
                default: begin
                    bx = ($urandom_range(0, 3) == 0) ? IN_W'($urandom)
                         : $signed(IN_W'($urandom_range(0, 1023))) - 16'sd512;
                    by = ($urandom_range(0, 3) == 0) ? IN_W'($urandom)
                         : $signed(IN_W'($urandom_range(0, 1023))) - 16'sd512;
                    gx = GAIN_W'($urandom >> $urandom_range(8, 24));
                    gy = GAIN_W'($urandom >> $urandom_range(8, 24));
                    load_config(bx, by, gx, gy, 1'($urandom));
                end
            endcase
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                if ($urandom_range(0, 63) == 0)
                    quiet_s = !quiet_s;
                // now and then hold off until the pipe is empty
                if ($urandom_range(0, 79) == 0)
                    drain_results();
                op  = ($urandom_range(0, 9) == 0) ? OP_SET_ZERO : OP_MEASURE;
                rx  = pick_raw(bias_x_q);
                ry  = pick_raw(bias_y_q);
                gap = quiet_s ? 0 : $urandom_range(0, MAX_GAP);
                send_beat(op, rx, ry, gap, 1'b0, '0);
            end
        end

        drain_results();
        // watch for stray beats after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d beats, %0d zero-offset updates.",
                 beats_checked, beats_sent, zero_sets);
        $display("Register settings loaded: %0d, random phases: %0d.",
                 settings_loaded, RAND_PHASES);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side: stall at random, then take and check one beat.
    initial begin : result_sink
        int       stall;
        bearing_t got;
        bearing_t want;
        quiet_m = 1'b0;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                quiet_m = !quiet_m;
            stall = quiet_m ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got.abs_deg = o_m_tdata[BEARING_W-1:0];
            got.rel_deg = o_m_tdata[2*BEARING_W-1:BEARING_W];
            if (pending_bearings.size() == 0) begin
                $error("unexpected result beat: real_bearing %0d, relative_bearing %0d",
                       got.abs_deg, got.rel_deg);
                failures++;
            end else begin
                want = pending_bearings.pop_front();
                beats_checked++;
                if (got.abs_deg !== want.abs_deg) begin
                    $error("real_bearing mismatch: expected %0d, got %0d",
                           want.abs_deg, got.abs_deg);
                    failures++;
                end
                if (got.rel_deg !== want.rel_deg) begin
                    $error("relative_bearing mismatch: expected %0d, got %0d",
                           want.rel_deg, got.rel_deg);
                    failures++;
                end
            end
        end
    end

    // Hard stop: the slowest legal run is well under 1 ms of simulated time.
    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d result beats outstanding.", pending_bearings.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: magnetometer_heading_core.f
design/mhdg_pkg.sv
design/mhdg_scale.sv
design/mhdg_cordic.sv
design/mhdg_wrap.sv
design/magnetometer_heading_core.sv
tb/sv/magnetometer_heading_core_tb.sv
